// File: hdl/asl_pkg.sv
package asl_pkg;

  // one trial
  typedef struct packed {
    logic answer_correct;
    logic update_step;
  } in_t;

  // one result
  typedef struct packed {
    logic signed [15:0] level;
    logic               saturated;
    logic [15:0]        reversal_total;
    logic [15:0]        step_now;
  } out_t;

  // configuration registers as seen by the datapath
  typedef struct packed {
    logic [3:0]         down_count;
    logic [3:0]         up_count;
    logic [3:0]         mode_flags;
    logic signed [15:0] max_level;
    logic signed [15:0] min_level;
    logic signed [15:0] start_level;
    logic [63:0]        step_table_low;
    logic [63:0]        step_table_high;
  } cfg_t;

  typedef enum logic [2:0] {
    RegDownCount     = 3'd0,
    RegUpCount       = 3'd1,
    RegModeFlags     = 3'd2,
    RegMaxLevel      = 3'd3,
    RegMinLevel      = 3'd4,
    RegStartLevel    = 3'd5,
    RegStepTableLow  = 3'd6,
    RegStepTableHigh = 3'd7
  } reg_idx_t;

  // mode_flags bits
  localparam int ModeLargerEasier = 0;
  localparam int ModeClampUp      = 1;
  localparam int ModeClampDown    = 2;
  localparam int ModeByTrials     = 3;

  localparam logic [3:0]  RunMax   = 4'hF;
  localparam logic [15:0] CountMax = 16'hFFFF;

  localparam int EntryBits  = 32;
  localparam int TableBits  = 128;
  localparam int MaxEntries = TableBits / EntryBits;

  localparam logic [3:0] DownCountRst = 4'd2;
  localparam logic [3:0] UpCountRst   = 4'd1;
  localparam logic [3:0] ModeFlagsRst = 4'd7;

endpackage

// File: hdl/asl_step_sel.sv
// Step table search: last entry whose threshold is at or below count wins.
module asl_step_sel #(
  parameter int STEP_ENTRIES = 4
) (
  input  logic [asl_pkg::TableBits-1:0] tbl,
  input  logic [15:0]                   count,
  output logic                          hit,
  output logic [15:0]                   step
);

  always_comb begin
    hit  = 1'b0;
    step = '0;
    for (int i = 0; i < STEP_ENTRIES && i < asl_pkg::MaxEntries; i++) begin
      if (tbl[asl_pkg::EntryBits*i+16 +: 16] <= count) begin
        hit  = 1'b1;
        step = tbl[asl_pkg::EntryBits*i +: 16];
      end
    end
  end

endmodule

// File: hdl/asl_core.sv
// Staircase state and the combinational update for one trial.
module asl_core #(
  parameter int STEP_ENTRIES = 4,
  parameter int LEVEL_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  asl_pkg::cfg_t   cfg,
  input  logic            take,
  input  asl_pkg::in_t    item,
  output asl_pkg::out_t   res
);

  // room for a 16-bit level plus a 16-bit step without overflow
  localparam int CW = ((LEVEL_BITS > 16) ? LEVEL_BITS : 16) + 2;
  localparam logic signed [CW-1:0] LvlHi =
    {{(CW-LEVEL_BITS+1){1'b0}}, {(LEVEL_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] LvlLo = ~LvlHi;

  logic signed [LEVEL_BITS-1:0] cur_level;
  logic [3:0]  correct_run, wrong_run;
  logic [15:0] reversals, trials, cur_step;
  logic        moving_harder, adapted_once, sat_flag;

  logic signed [LEVEL_BITS-1:0] cur_level_next;
  logic [3:0]  correct_run_next, wrong_run_next, cr, wr;
  logic [15:0] reversals_next, trials_next, cur_step_next, count;
  logic        moving_harder_next, adapted_once_next, sat_flag_next;
  logic        harder, easier, rev_hit, larger_easier, go_down, sel_hit;
  logic [15:0] sel_step;
  logic signed [CW-1:0] base, step_ext, moved, clamped, lvl;
  logic        clamp_hit;

  assign larger_easier = cfg.mode_flags[asl_pkg::ModeLargerEasier];
  assign trials_next   = (trials == asl_pkg::CountMax) ? trials : trials + 16'd1;

  assign cr = item.answer_correct ?
              ((correct_run == asl_pkg::RunMax) ? correct_run : correct_run + 4'd1) : 4'd0;
  assign wr = item.answer_correct ? 4'd0 :
              ((wrong_run == asl_pkg::RunMax) ? wrong_run : wrong_run + 4'd1);

  assign harder = (cfg.down_count != 4'd0) && (cr == cfg.down_count);
  assign easier = !harder && (cfg.up_count != 4'd0) && (wr == cfg.up_count);

  // reversal: direction flips after the first move
  assign rev_hit = adapted_once && ((harder && !moving_harder) || (easier && moving_harder))
                   && (reversals != asl_pkg::CountMax);
  assign reversals_next = rev_hit ? reversals + 16'd1 : reversals;

  assign count = cfg.mode_flags[asl_pkg::ModeByTrials] ? trials_next : reversals_next;

  asl_step_sel #(.STEP_ENTRIES(STEP_ENTRIES)) u_step_sel (
    .tbl   ({cfg.step_table_high, cfg.step_table_low}),
    .count (count),
    .hit   (sel_hit),
    .step  (sel_step)
  );

  assign cur_step_next = (item.update_step && sel_hit) ? sel_step : cur_step;

  assign base     = (trials == 16'd0) ? CW'(cfg.start_level) : CW'(cur_level);
  assign step_ext = signed'({{(CW-16){1'b0}}, cur_step_next});
  assign go_down  = (harder && larger_easier) || (easier && !larger_easier);

  always_comb begin
    if (!harder && !easier) begin
      moved = base;
    end else if (go_down) begin
      moved = base - step_ext;
    end else begin
      moved = base + step_ext;
    end
  end

  always_comb begin
    clamp_hit = 1'b0;
    clamped   = moved;
    if (moved > CW'(cfg.max_level) && cfg.mode_flags[asl_pkg::ModeClampUp]) begin
      clamp_hit = 1'b1;
      clamped   = CW'(cfg.max_level);
    end else if (moved < CW'(cfg.min_level) && cfg.mode_flags[asl_pkg::ModeClampDown]) begin
      clamp_hit = 1'b1;
      clamped   = CW'(cfg.min_level);
    end
    lvl = clamped;
    if (clamped > LvlHi) begin
      clamp_hit = 1'b1;
      lvl       = LvlHi;
    end else if (clamped < LvlLo) begin
      clamp_hit = 1'b1;
      lvl       = LvlLo;
    end
  end

  assign cur_level_next     = lvl[LEVEL_BITS-1:0];
  assign sat_flag_next      = sat_flag || clamp_hit;
  assign correct_run_next   = harder ? 4'd0 : cr;
  assign wrong_run_next     = easier ? 4'd0 : wr;
  assign moving_harder_next = harder ? 1'b1 : (easier ? 1'b0 : moving_harder);
  assign adapted_once_next  = adapted_once || harder || easier;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level     <= '0;
      correct_run   <= '0;
      wrong_run     <= '0;
      reversals     <= '0;
      trials        <= '0;
      cur_step      <= '0;
      moving_harder <= 1'b0;
      adapted_once  <= 1'b0;
      sat_flag      <= 1'b0;
    end else if (take) begin
      cur_level     <= cur_level_next;
      correct_run   <= correct_run_next;
      wrong_run     <= wrong_run_next;
      reversals     <= reversals_next;
      trials        <= trials_next;
      cur_step      <= cur_step_next;
      moving_harder <= moving_harder_next;
      adapted_once  <= adapted_once_next;
      sat_flag      <= sat_flag_next;
    end
  end

  always_comb begin
    res.level          = lvl[15:0];
    res.saturated      = sat_flag_next;
    res.reversal_total = reversals_next;
    res.step_now       = cur_step_next;
  end

  a_sat_sticky: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $past(sat_flag)) |-> sat_flag)
    else $error("sat_flag cleared outside reset");

  a_rev_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (reversals >= $past(reversals)))
    else $error("reversal count went down");

endmodule

// File: hdl/asl_out_buf.sv
// Two-entry result buffer: output register plus skid entry.
module asl_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  asl_pkg::out_t din,
  output logic          full,
  output logic          out_valid,
  input  logic          out_stall,
  output asl_pkg::out_t dout
);

  logic [1:0]    count;
  asl_pkg::out_t head, skid;
  logic          pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign dout      = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case (count)
        2'd0: begin
          if (push) begin
            head  <= din;
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (push && pop) begin
            head <= din;
          end else if (push) begin
            skid  <= din;
            count <= 2'd2;
          end else if (pop) begin
            count <= 2'd0;
          end
        end
        2'd2: begin
          if (pop) begin
            head  <= skid;
            count <= 2'd1;
          end
        end
        default: count <= 2'd0;
      endcase
    end
  end

endmodule

// File: hdl/adaptive_staircase_level.sv
// Adaptive up-down staircase level tracker, signed Q8.8.
// Input channel (in_valid / in_stall / in_data): one trial per transfer,
// carrying answer_correct and update_step. Output channel (out_valid /
// out_stall / out_data): one result per trial with the new level, the sticky
// saturated flag, the reversal count and the step in use.
// Configuration: write cfg_data to register cfg_index when cfg_we is high;
// only while no trial is in flight.
// Each trial's result is formed combinationally and registered in the result buffer.
// One trial per cycle while in_stall is low; the whole state update (run counters,
// table search, level add and clamps) is combinational and feeds the next trial.
// A two-entry result buffer sits at the output. If the receiver stalls, up to
// two results are held and in_stall rises once both are occupied; it drops as
// soon as a result transfers out. Nothing is dropped or repeated.
// Reset (synchronous, rst high): staircase state cleared, buffer emptied,
// down_count=2, up_count=1, mode_flags=7, all other registers zero.
module adaptive_staircase_level #(
  parameter int STEP_ENTRIES = 4,
  parameter int LEVEL_BITS   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  asl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output asl_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [63:0]   cfg_data
);

  asl_pkg::cfg_t cfg;
  asl_pkg::out_t res;
  logic          take;
  logic          full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.down_count      <= asl_pkg::DownCountRst;
      cfg.up_count        <= asl_pkg::UpCountRst;
      cfg.mode_flags      <= asl_pkg::ModeFlagsRst;
      cfg.max_level       <= '0;
      cfg.min_level       <= '0;
      cfg.start_level     <= '0;
      cfg.step_table_low  <= '0;
      cfg.step_table_high <= '0;
    end else if (cfg_we) begin
      unique case (asl_pkg::reg_idx_t'(cfg_index))
        asl_pkg::RegDownCount:     cfg.down_count      <= cfg_data[3:0];
        asl_pkg::RegUpCount:       cfg.up_count        <= cfg_data[3:0];
        asl_pkg::RegModeFlags:     cfg.mode_flags      <= cfg_data[3:0];
        asl_pkg::RegMaxLevel:      cfg.max_level       <= cfg_data[15:0];
        asl_pkg::RegMinLevel:      cfg.min_level       <= cfg_data[15:0];
        asl_pkg::RegStartLevel:    cfg.start_level     <= cfg_data[15:0];
        asl_pkg::RegStepTableLow:  cfg.step_table_low  <= cfg_data;
        asl_pkg::RegStepTableHigh: cfg.step_table_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_stall = full;
  assign take     = in_valid && !in_stall;

  asl_core #(
    .STEP_ENTRIES (STEP_ENTRIES),
    .LEVEL_BITS   (LEVEL_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .take (take),
    .item (in_data),
    .res  (res)
  );

  asl_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (take),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (out_data)
  );

  a_stall_needs_backlog: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted trial produced no result");

endmodule

// File: test/tb_top.sv
module tb_top;
  import asl_pkg::*;

  localparam int LevelBits  = 16;
  localparam int LevelHi    = (1 << (LevelBits - 1)) - 1;
  localparam int LevelLo    = -(1 << (LevelBits - 1));
  localparam int StallLimit = 4000;
  localparam int HoldCycles = 64;
  localparam int PlanLen    = 39;
  localparam int Phases     = 12;
  localparam int PhaseLen   = 150;
  localparam int SoakLen    = 100;

  localparam logic [3:0] FlagLargerEasier = 4'(1 << ModeLargerEasier);
  localparam logic [3:0] FlagClampUp      = 4'(1 << ModeClampUp);
  localparam logic [3:0] FlagClampDown    = 4'(1 << ModeClampDown);
  localparam logic [3:0] FlagByTrials     = 4'(1 << ModeByTrials);

  typedef struct packed {
    logic     is_cfg;
    reg_idx_t idx;
    logic [63:0] data;
    in_t      trial;
    logic     typed;
    out_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // register shadow
  logic [3:0]         n_down = DownCountRst;
  logic [3:0]         n_up = UpCountRst;
  logic [3:0]         mode = ModeFlagsRst;
  logic signed [15:0] lvl_max = '0;
  logic signed [15:0] lvl_min = '0;
  logic signed [15:0] lvl_start = '0;
  logic [63:0]        tab_lo = '0;
  logic [63:0]        tab_hi = '0;

  // staircase state as predicted
  logic signed [15:0] lvl_now = '0;
  logic [3:0]         run_ok = '0;
  logic [3:0]         run_bad = '0;
  logic [15:0]        rev_cnt = '0;
  logic [15:0]        trial_cnt = '0;
  logic               heading_harder = 1'b0;
  logic               has_moved = 1'b0;
  logic               clamped = 1'b0;
  logic [15:0]        step_sz = '0;

  out_t pending[$];
  out_t due;
  row_t plan [PlanLen];

  int   bad = 0;
  int   checked = 0;
  int   sent = 0;
  int   setups = 0;
  int   idle_run = 0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   hold_left = 0;
  logic no_gaps = 1'b0;

  adaptive_staircase_level DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // last table entry at or below the count wins; no match keeps the step
  function automatic logic [15:0] lookup_step();
    logic [127:0] tab;
    logic [15:0]  cnt;
    logic [15:0]  pick;
    tab  = {tab_hi, tab_lo};
    cnt  = mode[ModeByTrials] ? trial_cnt : rev_cnt;
    pick = step_sz;
    for (int k = 0; k < MaxEntries; k++) begin
      if (tab[32*k+16 +: 16] <= cnt) pick = tab[32*k +: 16];
    end
    return pick;
  endfunction

  function automatic out_t staircase_next(in_t t);
    int   lv;
    int   st;
    out_t r;
    if (trial_cnt == 16'd0) lvl_now = lvl_start;
    if (trial_cnt != CountMax) trial_cnt++;
    if (t.answer_correct) begin
      if (run_ok != RunMax) run_ok++;
      run_bad = '0;
    end else begin
      if (run_bad != RunMax) run_bad++;
      run_ok = '0;
    end
    lv = lvl_now;
    if (n_down != 0 && run_ok == n_down) begin
      if (has_moved && !heading_harder && rev_cnt != CountMax) rev_cnt++;
      if (t.update_step) step_sz = lookup_step();
      st = step_sz;
      heading_harder = 1'b1;
      lv = mode[ModeLargerEasier] ? lv - st : lv + st;
      run_ok = '0;
      has_moved = 1'b1;
    end else if (n_up != 0 && run_bad == n_up) begin
      if (has_moved && heading_harder && rev_cnt != CountMax) rev_cnt++;
      if (t.update_step) step_sz = lookup_step();
      st = step_sz;
      heading_harder = 1'b0;
      lv = mode[ModeLargerEasier] ? lv + st : lv - st;
      run_bad = '0;
      has_moved = 1'b1;
    end else if (t.update_step) begin
      step_sz = lookup_step();
    end
    if (lv > lvl_max && mode[ModeClampUp]) begin
      clamped = 1'b1;
      lv = lvl_max;
    end else if (lv < lvl_min && mode[ModeClampDown]) begin
      clamped = 1'b1;
      lv = lvl_min;
    end
    if (lv > LevelHi) begin
      lv = LevelHi;
      clamped = 1'b1;
    end
    if (lv < LevelLo) begin
      lv = LevelLo;
      clamped = 1'b1;
    end
    lvl_now = lv[15:0];
    r.level = lvl_now;
    r.saturated = clamped;
    r.reversal_total = rev_cnt;
    r.step_now = step_sz;
    return r;
  endfunction

  function automatic row_t cfg_row(reg_idx_t r, logic [63:0] v);
    row_t x;
    x = '0;
    x.is_cfg = 1'b1;
    x.idx = r;
    x.data = v;
    return x;
  endfunction

  function automatic row_t trial_row(logic c, logic u);
    row_t x;
    x = '0;
    x.trial.answer_correct = c;
    x.trial.update_step = u;
    return x;
  endfunction

  function automatic row_t typed_row(logic c, logic u, out_t w);
    row_t x;
    x = trial_row(c, u);
    x.typed = 1'b1;
    x.want = w;
    return x;
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'($urandom);
      default: return 16'($urandom_range(0, 16'h0C00)) - 16'h0600;
    endcase
  endfunction

  function automatic logic [3:0] rand_count();
    case ($urandom_range(0, 7))
      0: return 4'd0;
      1: return RunMax;
      default: return 4'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [15:0] rand_step();
    case ($urandom_range(0, 9))
      0: return 16'hFFFF;
      1: return 16'($urandom);
      2: return 16'h0000;
      default: return 16'($urandom_range(1, 16'h0200));
    endcase
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_trial(in_t t, logic typed, out_t w);
    out_t p;
    cfg_we <= 1'b0;
    if (!no_gaps && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(0, 99) < 20);
    end
    in_valid <= 1'b1;
    in_data <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = staircase_next(t);
    pending.push_back(typed ? w : p);
    sent++;
    @(negedge clk);
  endtask

  // block must be empty before any register write
  task automatic quiesce();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      RegDownCount:     n_down = v[3:0];
      RegUpCount:       n_up = v[3:0];
      RegModeFlags:     mode = v[3:0];
      RegMaxLevel:      lvl_max = v[15:0];
      RegMinLevel:      lvl_min = v[15:0];
      RegStartLevel:    lvl_start = v[15:0];
      RegStepTableLow:  tab_lo = v;
      RegStepTableHigh: tab_hi = v;
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic apply_random_setup();
    logic [3:0]   m;
    logic [15:0]  th;
    logic [127:0] tab;
    quiesce();
    m = 4'($urandom_range(0, 15));
    write_reg(RegDownCount, 64'(rand_count()));
    write_reg(RegUpCount, 64'(rand_count()));
    write_reg(RegModeFlags, 64'(m));
    write_reg(RegMaxLevel, 64'(rand_level()));
    write_reg(RegMinLevel, 64'(rand_level()));
    write_reg(RegStartLevel, 64'(rand_level()));
    // thresholds start near the count in use so the selection changes mid-phase
    th = (m[ModeByTrials] ? trial_cnt : rev_cnt) + 16'($urandom_range(0, 6));
    for (int k = 0; k < MaxEntries; k++) begin
      if ($urandom_range(0, 5) == 0) th = 16'($urandom);
      tab[32*k +: 32] = {th, rand_step()};
      th = th + 16'(m[ModeByTrials] ? $urandom_range(0, 50) : $urandom_range(0, 6));
    end
    write_reg(RegStepTableLow, tab[63:0]);
    write_reg(RegStepTableHigh, tab[127:64]);
    setups++;
  endtask

  task automatic run_phase(int n, int ok_pct, int upd_pct, logic squeeze);
    in_t t;
    for (int i = 0; i < n; i++) begin
      if (squeeze && i == 20) hold_asked <= hold_asked + 1;
      t.answer_correct = ($urandom_range(0, 99) < ok_pct);
      t.update_step = ($urandom_range(0, 99) < upd_pct);
      send_trial(t, 1'b0, '0);
    end
  endtask

  // receiver: random stall, or a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left <= HoldCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_gaps && ($urandom_range(0, 99) < 11);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("result with nothing pending: level %h sat %b rev %0d step %h",
                     out_data.level, out_data.saturated, out_data.reversal_total,
                     out_data.step_now);
        end else begin
          due = pending.pop_front();
          checked++;
          if (out_data.level !== due.level || out_data.saturated !== due.saturated ||
              out_data.reversal_total !== due.reversal_total ||
              out_data.step_now !== due.step_now) begin
            bad++;
            if (bad <= 10)
              $display("result %0d: want level %h sat %b rev %0d step %h, ",
                       checked, due.level, due.saturated, due.reversal_total,
                       due.step_now, "got level %h sat %b rev %0d step %h",
                       out_data.level, out_data.saturated, out_data.reversal_total,
                       out_data.step_now);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_run = 0;
      end else begin
        idle_run++;
        if (idle_run == StallLimit) begin
          $display("watchdog: no transfer for %0d cycles, %0d results pending",
                   idle_run, pending.size());
          $display("tb_top failed");
          $finish;
        end
      end
    end
  end

  initial begin
    in_t t;
    plan = '{
      cfg_row(RegMaxLevel, 64'h7FFF),
      cfg_row(RegMinLevel, 64'h8000),
      cfg_row(RegStartLevel, 64'h1234),
      cfg_row(RegStepTableLow, 64'h0002_0080_0000_0100),
      cfg_row(RegStepTableHigh, 64'h0005_0040_FFFF_FFFF),
      // first trial loads start_level, step from entry 0
      typed_row(1'b1, 1'b1, {16'h1234, 1'b0, 16'd0, 16'h0100}),
      trial_row(1'b1, 1'b0),
      trial_row(1'b0, 1'b1),
      trial_row(1'b1, 1'b1),
      trial_row(1'b1, 1'b1),
      trial_row(1'b0, 1'b0),
      trial_row(1'b1, 1'b1),
      trial_row(1'b1, 1'b0),
      trial_row(1'b0, 1'b1),
      trial_row(1'b0, 1'b0),
      // zero down count: correct answers never move the level
      cfg_row(RegDownCount, 64'd0),
      cfg_row(RegUpCount, 64'(RunMax)),
      cfg_row(RegModeFlags, 64'(FlagClampUp)),
      cfg_row(RegMaxLevel, 64'h1000),
      trial_row(1'b1, 1'b1),
      trial_row(1'b0, 1'b1),
      trial_row(1'b1, 1'b0),
      // full-scale step overruns the level range both ways
      cfg_row(RegDownCount, 64'd1),
      cfg_row(RegModeFlags, 64'(FlagByTrials)),
      cfg_row(RegStepTableLow, 64'h0000_FFFF_0000_0001),
      cfg_row(RegStepTableHigh, 64'hFFFF_0010_FFFF_0020),
      trial_row(1'b1, 1'b1),
      trial_row(1'b1, 1'b0),
      trial_row(1'b0, 1'b0),
      cfg_row(RegModeFlags, 64'(FlagLargerEasier | FlagByTrials)),
      trial_row(1'b1, 1'b1),
      trial_row(1'b1, 1'b0),
      cfg_row(RegModeFlags, 64'(FlagClampDown)),
      cfg_row(RegMinLevel, 64'h0100),
      cfg_row(RegUpCount, 64'd2),
      cfg_row(RegStepTableLow, 64'h0001_0020_0000_0010),
      trial_row(1'b0, 1'b1),
      trial_row(1'b0, 1'b0),
      trial_row(1'b1, 1'b1)
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < PlanLen; r++) begin
      if (plan[r].is_cfg) begin
        if (r == 0 || !plan[r-1].is_cfg) quiesce();
        write_reg(plan[r].idx, plan[r].data);
      end else begin
        send_trial(plan[r].trial, plan[r].typed, plan[r].want);
      end
    end
    setups++;

    for (int ph = 0; ph < Phases; ph++) begin
      apply_random_setup();
      if (ph == 5) no_gaps <= 1'b1;
      case (ph % 4)
        0: run_phase(PhaseLen, 50, (ph % 3) * 40 + 10, ph == 2 || ph == 9);
        1: run_phase(PhaseLen, 85, (ph % 3) * 40 + 10, ph == 2 || ph == 9);
        2: run_phase(PhaseLen, 95, (ph % 3) * 40 + 10, ph == 2 || ph == 9);
        default: run_phase(PhaseLen, 20, (ph % 3) * 40 + 10, ph == 2 || ph == 9);
      endcase
      if (ph == 5) no_gaps <= 1'b0;
    end

    // alternate answers with unit counts: every move after the first is a reversal,
    // so the reversal count climbs past the 0x40 table threshold
    quiesce();
    write_reg(RegDownCount, 64'd1);
    write_reg(RegUpCount, 64'd1);
    write_reg(RegModeFlags, 64'(FlagClampUp | FlagClampDown));
    write_reg(RegMaxLevel, 64'h0800);
    write_reg(RegMinLevel, 64'hF800);
    write_reg(RegStepTableLow, 64'h8000_0020_0000_0010);
    write_reg(RegStepTableHigh, 64'hFFFF_0040_0040_0030);
    setups++;
    no_gaps <= 1'b1;
    for (int i = 0; i < SoakLen; i++) begin
      t.answer_correct = i[0];
      t.update_step = ($urandom_range(0, 99) < 25);
      send_trial(t, 1'b0, '0);
    end
    no_gaps <= 1'b0;

    // thresholds out of reach: only the first entry ever matches
    quiesce();
    write_reg(RegModeFlags, 64'(FlagLargerEasier | FlagClampUp | FlagByTrials));
    write_reg(RegStepTableLow, 64'hFFFF_0005_0000_0100);
    write_reg(RegStepTableHigh, 64'hFFFF_0009_FFFF_0007);
    setups++;
    run_phase(30, 50, 50, 1'b0);

    quiesce();
    repeat (4) @(posedge clk);
    $display("%0d trials, %0d results checked across %0d register setups", sent, checked,
             setups);
    $display("reversal count ended at %0d, trial count at %0d, clamp flag %b",
             rev_cnt, trial_cnt, clamped);
    if (bad == 0) begin
      $display("tb_top passed");
    end else begin
      $display("%0d failed checks", bad);
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
